/* hdl/pwli_pkg.sv */
// Shared constants for the piecewise-linear table interpolator.
// Used by pwli_div, piecewise_linear_table_interp and the testbench; depends on nothing.
`default_nettype none

package pwli_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam int XW = 17;
  localparam int YW = 32;
  localparam int DYW = YW + 1;
  localparam int PW = DYW + XW;
  localparam int MAGW = PW - 1;
  localparam int QW = YW;
  localparam int QCW = $clog2(QW);

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

endpackage

`default_nettype wire

/* hdl/piecewise_linear_table_interp.sv */
// Piecewise-linear interpolation over a table of breakpoints.
// Top level: sequencer, breakpoint memory and output register; uses pwli_pkg and pwli_div.
//
// Usage: one input channel (in_valid_i / in_stall_o) carries clear, append and
// query beats; one output channel (out_valid_o / out_stall_i) carries one result
// beat per query. Clear and append complete in the cycle they are accepted and
// produce no result. A query holds the input stalled while it runs: a range
// check reads the first and last breakpoints, an upper-bound binary search
// probes the memory at one read a cycle with registered read data, the
// bracketing pair is read, one multiply forms (y1-y0)*(x-x0), and a
// radix-2 divider forms the quotient. An in-range query needs two
// to seven probes. Empty-table queries go straight to the result, queries
// below the first point end after the first-point check, and queries at or
// above the last point after the last-point check. The input is taken again
// in the cycle after the result loads.
// The result sits in an output register, so the next beat is accepted while
// it waits; a further query completes only once that result is taken.
// Reset empties the table and drops any pending result. Memory contents are
// not cleared; only entries below the point count are ever read.
`default_nettype none

module piecewise_linear_table_interp
  import pwli_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           kind_i,
  input  wire logic [XW-1:0]        sat_x_i,
  input  wire logic signed [YW-1:0] point_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      found_o,
  output logic signed [YW-1:0]      interp_value_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_LAST, S_PROBE, S_LOWER, S_UPPER, S_MUL, S_START, S_DIV, S_OUT
  } state_e;

  state_e               state_q;
  logic [CW-1:0]        cnt_q;
  logic [XW-1:0]        x_q;
  logic [CW-1:0]        lo_q;
  logic [CW-1:0]        hi_q;
  logic [XW-1:0]        x0_q;
  logic [YW-1:0]        y0_q;
  logic signed [DYW-1:0] dy_q;
  logic [XW-1:0]        xo_q;
  logic [XW-1:0]        dx_q;
  logic signed [PW-1:0] prod_q;
  logic                 res_found_q;
  logic [YW-1:0]        res_value_q;
  logic                 out_valid_q;
  logic                 found_q;
  logic [YW-1:0]        value_q;

  logic [XW-1:0] mem_x [TABLE_DEPTH];
  logic [YW-1:0] mem_y [TABLE_DEPTH];
  logic [XW-1:0] rd_x_q;
  logic [YW-1:0] rd_y_q;
  logic [AW-1:0] mem_addr;
  logic          mem_we;

  logic               accept;
  logic               probe_le;
  logic [CW-1:0]      cnt_m1;
  logic signed [PW:0] mul_full;
  logic [PW-1:0]      prod_neg;
  logic [MAGW-1:0]    mag;
  logic               div_start;
  logic               div_done;
  logic [QW-1:0]      quo;
  logic [YW-1:0]      quo_signed;
  logic               out_load;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign mem_we     = accept && (kind_i == KIND_APPEND) && (cnt_q < CW'(TABLE_DEPTH));
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    probe_le = rd_x_q <= x_q;
    cnt_m1   = cnt_q - 1'b1;
  end

  logic [AW-1:0] mid_q;
  logic [CW-1:0] s_lo;
  logic [CW-1:0] s_hi;
  logic [CW:0]   s_sum;
  logic [CW:0]   s_half;
  logic [CW-1:0] s_lo_m1;
  logic          s_go;

  always_comb begin
    if (state_q == S_LAST) begin
      s_lo = '0;
      s_hi = cnt_q;
    end else if (probe_le) begin
      s_lo = CW'(mid_q) + 1'b1;
      s_hi = hi_q;
    end else begin
      s_lo = lo_q;
      s_hi = CW'(mid_q);
    end
    s_sum   = {1'b0, s_lo} + {1'b0, s_hi};
    s_half  = s_sum >> 1;
    s_lo_m1 = s_lo - 1'b1;
    s_go    = s_lo < s_hi;
  end

  always_comb begin
    case (state_q)
      S_FIRST:         mem_addr = cnt_m1[AW-1:0];
      S_LAST, S_PROBE: mem_addr = s_go ? s_half[AW-1:0] : s_lo_m1[AW-1:0];
      S_LOWER:         mem_addr = lo_q[AW-1:0];
      default:         mem_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_x[cnt_q[AW-1:0]] <= sat_x_i;
      mem_y[cnt_q[AW-1:0]] <= point_value_i;
    end
    rd_x_q <= mem_x[mem_addr];
    rd_y_q <= mem_y[mem_addr];
  end

  always_comb begin
    mul_full   = dy_q * $signed({1'b0, xo_q});
    prod_neg   = -prod_q;
    mag        = prod_q[PW-1] ? prod_neg[MAGW-1:0] : prod_q[MAGW-1:0];
    div_start  = (state_q == S_START);
    quo_signed = prod_q[PW-1] ? (~quo + 1'b1) : quo;
  end

  pwli_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  (dx_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      x_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      x0_q        <= '0;
      y0_q        <= '0;
      dy_q        <= '0;
      xo_q        <= '0;
      dx_q        <= '0;
      prod_q      <= '0;
      res_found_q <= 1'b0;
      res_value_q <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      value_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (kind_i)
              KIND_CLEAR: begin
                cnt_q <= '0;
              end
              KIND_APPEND: begin
                if (mem_we) begin
                  cnt_q <= cnt_q + 1'b1;
                end
              end
              KIND_QUERY: begin
                x_q         <= sat_x_i;
                res_found_q <= 1'b0;
                res_value_q <= '0;
                state_q     <= (cnt_q == '0) ? S_OUT : S_FIRST;
              end
              default: begin
              end
            endcase
          end
        end
        S_FIRST: begin
          state_q <= (x_q < rd_x_q) ? S_OUT : S_LAST;
        end
        S_LAST: begin
          if (x_q > rd_x_q) begin
            state_q <= S_OUT;
          end else if (x_q == rd_x_q) begin
            res_found_q <= 1'b1;
            res_value_q <= rd_y_q;
            state_q     <= S_OUT;
          end else begin
            lo_q    <= s_lo;
            hi_q    <= s_hi;
            mid_q   <= s_half[AW-1:0];
            state_q <= S_PROBE;
          end
        end
        S_PROBE: begin
          // The range checks keep the final bound inside 1 .. count-1.
          lo_q  <= s_lo;
          hi_q  <= s_hi;
          mid_q <= s_half[AW-1:0];
          if (!s_go) begin
            state_q <= S_LOWER;
          end
        end
        S_LOWER: begin
          x0_q    <= rd_x_q;
          y0_q    <= rd_y_q;
          state_q <= S_UPPER;
        end
        S_UPPER: begin
          res_found_q <= 1'b1;
          if (rd_x_q <= x0_q) begin
            res_value_q <= y0_q;
            state_q     <= S_OUT;
          end else begin
            dy_q    <= $signed({rd_y_q[YW-1], rd_y_q}) - $signed({y0_q[YW-1], y0_q});
            xo_q    <= x_q - x0_q;
            dx_q    <= rd_x_q - x0_q;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= mul_full[PW-1:0];
          state_q <= S_START;
        end
        S_START: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_value_q <= y0_q + quo_signed;
            state_q     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
        found_q     <= res_found_q;
        value_q     <= res_value_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign interp_value_o = value_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH))
    else $error("point count exceeds table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PROBE |-> lo_q < hi_q)
    else $error("search bounds crossed during a probe");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> interp_value_o == '0)
    else $error("not-found result carries a nonzero value");

endmodule

`default_nettype wire

/* hdl/pwli_div.sv */
// Restoring divider that produces one quotient bit per cycle.
// Depends on pwli_pkg for the dividend, divisor and quotient widths.
`default_nettype none

module pwli_div
  import pwli_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [MAGW-1:0] dividend_i,
  input  wire logic [XW-1:0]   divisor_i,
  output logic                 done_o,
  output logic [QW-1:0]        quotient_o
);

  logic [XW-1:0]  rem_q;
  logic [QW-1:0]  sh_q;
  logic [QCW-1:0] cnt_q;
  logic           busy_q;
  logic           done_q;
  logic [XW:0]    trial;
  logic           fits;
  logic [XW:0]    diff;
  logic [XW-1:0]  rem_d;

  // The upper dividend bits start below the divisor, so the quotient fits QW bits.
  always_comb begin
    trial = {rem_q, sh_q[QW-1]};
    fits  = trial >= {1'b0, divisor_i};
    diff  = trial - {1'b0, divisor_i};
    rem_d = fits ? diff[XW-1:0] : trial[XW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      sh_q   <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= dividend_i[MAGW-1:QW];
        sh_q   <= dividend_i[QW-1:0];
        cnt_q  <= QCW'(QW - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= rem_d;
        sh_q  <= {sh_q[QW-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = sh_q;

endmodule

`default_nettype wire

/* dv/tb.sv */
// Testbench for piecewise_linear_table_interp: random and directed table builds and queries,
// checked beat by beat against a scoreboard that keeps its own breakpoint table.
// Depends on pwli_pkg and the piecewise_linear_table_interp RTL.
`timescale 1ns / 100ps

module tb
  import pwli_pkg::*;
();

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 950;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic          found;
    logic [YW-1:0] value;
  } interp_result_t;

  class interp_scoreboard;
    logic [XW-1:0]        tbl_x[TABLE_DEPTH];
    logic signed [YW-1:0] tbl_y[TABLE_DEPTH];
    int unsigned          n_points;
    interp_result_t       awaited_answers[$];
    int unsigned          n_errors;

    function new();
      n_points = 0;
      n_errors = 0;
    endfunction

    function int unsigned pending();
      return awaited_answers.size();
    endfunction

    function interp_result_t interpolate(input logic [XW-1:0] x);
      interp_result_t r;
      int unsigned    lo, hi, mid;
      longint         x0, x1, y0, y1, dx, num, sum;
      r.found = 1'b0;
      r.value = '0;
      if (n_points == 0) return r;
      if (x < tbl_x[0] || x > tbl_x[n_points-1]) return r;
      r.found = 1'b1;
      if (x == tbl_x[n_points-1]) begin
        r.value = tbl_y[n_points-1];
        return r;
      end
      lo = 0;
      hi = n_points;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (tbl_x[mid] <= x) lo = mid + 1;
        else hi = mid;
      end
      if (lo >= n_points) begin
        r.found = 1'b0;
        return r;
      end
      if (lo == 0) begin
        r.value = tbl_y[0];
        return r;
      end
      x0 = tbl_x[lo-1];
      x1 = tbl_x[lo];
      y0 = tbl_y[lo-1];
      y1 = tbl_y[lo];
      dx = x1 - x0;
      if (dx <= 0) begin
        r.value = y0[YW-1:0];
      end else begin
        num = (y1 - y0) * (longint'(x) - x0);
        sum = y0 + num / dx;
        r.value = sum[YW-1:0];
      end
      return r;
    endfunction

    function void note_input(input logic [1:0] kind, input logic [XW-1:0] x,
                             input logic [YW-1:0] y);
      case (kind)
        KIND_CLEAR: n_points = 0;
        KIND_APPEND: begin
          if (n_points < TABLE_DEPTH) begin
            tbl_x[n_points] = x;
            tbl_y[n_points] = y;
            n_points++;
          end
        end
        KIND_QUERY: awaited_answers = {awaited_answers, interpolate(x)};
        default: ;
      endcase
    endfunction

    task report(input string what, input logic [YW-1:0] got, input logic [YW-1:0] want);
      n_errors++;
      if (n_errors <= 100)
        $display("MISMATCH %s: got %h, expected %h at %0t ns", what, got, want, $time);
    endtask

    task check_result(input logic found, input logic [YW-1:0] value);
      interp_result_t want;
      if (awaited_answers.size() == 0) begin
        report("result beat with no query outstanding", value, '0);
      end else begin
        want = awaited_answers.pop_front();
        if (found !== want.found) report("found", YW'(found), YW'(want.found));
        if (value !== want.value) report("interp_value", value, want.value);
      end
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           kind_i;
  logic [XW-1:0]        sat_x_i;
  logic signed [YW-1:0] point_value_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 found_o;
  logic signed [YW-1:0] interp_value_o;

  interp_scoreboard sb;
  bit               no_idle = 1'b0;
  bit               hold_req = 1'b0;
  bit               hold_active = 1'b0;
  int unsigned      items_sent = 0;

  piecewise_linear_table_interp dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .sat_x_i        (sat_x_i),
    .point_value_i  (point_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .interp_value_o (interp_value_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [YW-1:0] pick_y();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3, 4: return YW'($urandom_range(0, 131072)) - 32'd65536;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [XW-1:0] x,
                           input logic [YW-1:0] y);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    sat_x_i       <= x;
    point_value_i <= y;
    do @(posedge clk_i); while (in_stall_o);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic random_table_run();
    int unsigned   n_app, n_qry, stored, span, r;
    bit            broken;
    logic [XW-1:0] xs[$];
    logic [XW-1:0] lo_x, hi_x, qx;
    broken = ($urandom_range(0, 99) < 12);
    no_idle = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 9) != 0) send_item(KIND_CLEAR, XW'($urandom), $urandom);
    r = $urandom_range(0, 99);
    n_app = (r < 85) ? $urandom_range(1, 10) :
            (r < 95) ? $urandom_range(11, 40) : $urandom_range(60, 70);
    span = ($urandom_range(0, 3) == 0) ? 32'h1FFFF : 32'h10000;
    for (int i = 0; i < n_app; i++) xs = {xs, XW'($urandom_range(0, span))};
    if (!broken) xs.sort();
    foreach (xs[i]) begin
      if (broken && $urandom_range(0, 5) == 0) send_item(KIND_UNUSED, XW'($urandom), $urandom);
      send_item(KIND_APPEND, xs[i], pick_y());
    end
    stored = (n_app > TABLE_DEPTH) ? TABLE_DEPTH : n_app;
    lo_x = xs[0];
    hi_x = xs[stored-1];
    n_qry = $urandom_range(2, 12);
    for (int i = 0; i < n_qry; i++) begin
      r = $urandom_range(0, 99);
      if (r < 65) qx = XW'($urandom_range(lo_x, hi_x));
      else if (r < 85) qx = xs[$urandom_range(0, stored-1)];
      else qx = XW'($urandom);
      if (broken && $urandom_range(0, 7) == 0) send_item(KIND_UNUSED, qx, $urandom);
      send_item(KIND_QUERY, qx, $urandom);
    end
    no_idle = 1'b0;
    if ($urandom_range(0, 19) == 0) wait_results_drained();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(found_o, interp_value_o);
      if (in_valid_i && !in_stall_o) sb.note_input(kind_i, sat_x_i, point_value_i);
    end
  end

  initial begin : receiver
    int stall_len;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active = 1'b0;
      end else begin
        stall_len = pick_gap();
        if (stall_len != 0) begin
          out_stall_i <= 1'b1;
          repeat (stall_len) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    sb = new();
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    kind_i        <= KIND_CLEAR;
    sat_x_i       <= '0;
    point_value_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(KIND_QUERY,  17'h00000, 32'h0000_0000);
    send_item(KIND_UNUSED, 17'h1FFFF, 32'hFFFF_FFFF);
    send_item(KIND_APPEND, 17'h00000, 32'h8000_0000);
    send_item(KIND_APPEND, 17'h08000, 32'h7FFF_FFFF);
    send_item(KIND_APPEND, 17'h10000, 32'h0000_0000);
    send_item(KIND_APPEND, 17'h1FFFF, 32'h1234_5678);
    send_item(KIND_QUERY,  17'h00000, 32'hFFFF_FFFF);
    send_item(KIND_QUERY,  17'h04000, 32'h0000_0000);
    send_item(KIND_QUERY,  17'h08000, 32'h0000_0000);
    send_item(KIND_QUERY,  17'h0C000, 32'h0000_0000);
    send_item(KIND_QUERY,  17'h10001, 32'h0000_0000);
    send_item(KIND_QUERY,  17'h1FFFF, 32'h0000_0000);
    send_item(KIND_CLEAR,  17'h1FFFF, 32'hFFFF_FFFF);
    send_item(KIND_APPEND, 17'd100,   32'd5);
    send_item(KIND_QUERY,  17'd100,   32'd0);
    send_item(KIND_QUERY,  17'd50,    32'd0);
    send_item(KIND_QUERY,  17'd200,   32'd0);
    send_item(KIND_APPEND, 17'd300,   32'd7);
    send_item(KIND_APPEND, 17'd200,   32'd9);
    send_item(KIND_QUERY,  17'd250,   32'd0);
    send_item(KIND_QUERY,  17'd150,   32'd0);
    send_item(KIND_APPEND, 17'd200,   -32'sd3);
    send_item(KIND_QUERY,  17'd250,   32'd0);
    send_item(KIND_QUERY,  17'd199,   32'd0);
    wait_results_drained();

    // The result register fills and the block must stall further queries.
    send_item(KIND_CLEAR,  17'd0,     32'd0);
    send_item(KIND_APPEND, 17'd1000,  -32'sd40000);
    send_item(KIND_APPEND, 17'd9000,  32'd123456);
    send_item(KIND_APPEND, 17'd20000, 32'd99);
    send_item(KIND_APPEND, 17'd60000, 32'h7FFF_0000);
    wait_results_drained();
    hold_req = 1'b1;
    wait (hold_active);
    @(posedge clk_i);
    for (int i = 0; i < 20; i++) send_item(KIND_QUERY, XW'($urandom_range(900, 60100)), $urandom);
    wait_results_drained();

    while (items_sent < ITEM_TARGET) random_table_run();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/pwli_pkg.sv
hdl/pwli_div.sv
hdl/piecewise_linear_table_interp.sv
dv/tb.sv
